[hw/rtl/scr_pkg.sv]
// Shared types, constants and Salsa20/8 helpers for the scrypt ROMix core.
package scr_pkg;

  // Widest command fields, sized for MAX_R = 4 and MAX_LOG2_N = 20.
  localparam int unsigned XADDR_W = 6;
  localparam int unsigned VADDR_W = 26;
  localparam int unsigned XLOW_W  = 20;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCK_FACTOR = 2'd0;
  localparam logic [1:0] CFG_LOG2_COST    = 2'd1;

  typedef logic [31:0] sword_t;

  typedef struct packed {
    sword_t a;
    sword_t b;
    sword_t c;
    sword_t d;
  } quad_t;

  // What to do with read data in the cycle after the read is issued.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOADX,
    OP_COPY
  } dp_op_e;

  typedef struct packed {
    logic                     in_we;
    logic                     cur;
    logic                     rd_en;
    logic                     rd_x;
    logic                     rd_v;
    logic [XADDR_W-1:0]       xaddr;
    logic [VADDR_W-1:0]       vaddr;
    dp_op_e                   op;
    logic [2:0]               slot;
    logic [VADDR_W-1:0]       waddr;
    logic [XADDR_W-1:0]       wxaddr;
    logic                     wr_en;
    logic                     wr_v;
    logic                     round_en;
    logic                     round_row;
    logic                     final_en;
  } dp_cmd_t;

  typedef struct packed {
    logic [XLOW_W-1:0] x0_low;
  } dp_sts_t;

  function automatic sword_t rotl(sword_t v, int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic quad_t quarter(quad_t q);
    quad_t o;
    o   = q;
    o.b = o.b ^ rotl(o.a + o.d, 7);
    o.c = o.c ^ rotl(o.b + o.a, 9);
    o.d = o.d ^ rotl(o.c + o.b, 13);
    o.a = o.a ^ rotl(o.d + o.c, 18);
    return o;
  endfunction

endpackage

[hw/rtl/scr_stream_if.sv]
// Valid/ready stream interfaces for the input and output words.
interface scr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] in_word;
  modport source (output valid, output in_word, input ready);
  modport sink   (input valid, input in_word, output ready);
endinterface

interface scr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word;
  logic        last_out;
  modport source (output valid, output out_word, output last_out, input ready);
  modport sink   (input valid, input out_word, input last_out, output ready);
endinterface

[hw/rtl/scr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module scr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/scr_dp.sv]
// ROMix datapath: work/mix banks, scratchpad and the Salsa20/8 round unit.
module scr_dp #(
  parameter int unsigned MAX_R      = 4,
  parameter int unsigned MAX_LOG2_N = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scr_pkg::dp_cmd_t cmd_i,
  input  logic [63:0]     in_word_i,
  output logic [63:0]     out_word_o,
  output scr_pkg::dp_sts_t sts_o
);
  localparam int unsigned XDEPTH = 16 * MAX_R;
  localparam int unsigned WW     = $clog2(XDEPTH);
  localparam int unsigned VAW    = WW + MAX_LOG2_N;
  localparam int unsigned VDEPTH = 2 ** VAW;

  scr_pkg::sword_t x_q [16];
  scr_pkg::sword_t x_d [16];
  scr_pkg::sword_t t_q [16];
  scr_pkg::sword_t rnd [16];

  scr_pkg::dp_op_e      dl_op_q;
  logic [2:0]           dl_slot_q;
  logic                 dl_rdx_q;
  logic                 dl_rdv_q;
  logic [VAW-1:0]       dl_waddr_q;

  logic [63:0] xr0, xr1, vr, xcur, rd_data, xword, x_wdata, v_wdata;
  logic [1:0]  x_we;
  logic        v_we;
  logic [WW-1:0]  x_waddr;
  logic [VAW-1:0] v_waddr;

  // Read-side op is applied when the registered read data shows up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dl_op_q <= scr_pkg::OP_NONE;
      dl_rdx_q <= 1'b0;
      dl_rdv_q <= 1'b0;
    end else begin
      dl_op_q <= cmd_i.op;
      dl_rdx_q <= cmd_i.rd_x;
      dl_rdv_q <= cmd_i.rd_v;
    end
  end

  always_ff @(posedge clk_i) begin
    dl_slot_q  <= cmd_i.slot;
    dl_waddr_q <= cmd_i.waddr[VAW-1:0];
  end

  assign xcur    = cmd_i.cur ? xr1 : xr0;
  assign rd_data = (dl_rdx_q ? xcur : 64'd0) ^ (dl_rdv_q ? vr : 64'd0);
  assign xword   = {x_q[{cmd_i.slot, 1'b1}], x_q[{cmd_i.slot, 1'b0}]};

  // One column or row half-round: four independent quarter rounds.
  always_comb begin
    scr_pkg::quad_t q0, q1, q2, q3;
    for (int i = 0; i < 16; i++) begin
      rnd[i] = x_q[i];
    end
    if (!cmd_i.round_row) begin
      q0 = scr_pkg::quarter({x_q[0],  x_q[4],  x_q[8],  x_q[12]});
      q1 = scr_pkg::quarter({x_q[5],  x_q[9],  x_q[13], x_q[1]});
      q2 = scr_pkg::quarter({x_q[10], x_q[14], x_q[2],  x_q[6]});
      q3 = scr_pkg::quarter({x_q[15], x_q[3],  x_q[7],  x_q[11]});
      {rnd[0],  rnd[4],  rnd[8],  rnd[12]} = q0;
      {rnd[5],  rnd[9],  rnd[13], rnd[1]}  = q1;
      {rnd[10], rnd[14], rnd[2],  rnd[6]}  = q2;
      {rnd[15], rnd[3],  rnd[7],  rnd[11]} = q3;
    end else begin
      q0 = scr_pkg::quarter({x_q[0],  x_q[1],  x_q[2],  x_q[3]});
      q1 = scr_pkg::quarter({x_q[5],  x_q[6],  x_q[7],  x_q[4]});
      q2 = scr_pkg::quarter({x_q[10], x_q[11], x_q[8],  x_q[9]});
      q3 = scr_pkg::quarter({x_q[15], x_q[12], x_q[13], x_q[14]});
      {rnd[0],  rnd[1],  rnd[2],  rnd[3]}  = q0;
      {rnd[5],  rnd[6],  rnd[7],  rnd[4]}  = q1;
      {rnd[10], rnd[11], rnd[8],  rnd[9]}  = q2;
      {rnd[15], rnd[12], rnd[13], rnd[14]} = q3;
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      x_d[i] = x_q[i];
    end
    if (cmd_i.round_en) begin
      for (int i = 0; i < 16; i++) begin
        x_d[i] = rnd[i];
      end
    end else if (cmd_i.final_en) begin
      for (int i = 0; i < 16; i++) begin
        x_d[i] = x_q[i] + t_q[i];
      end
    end else if (dl_op_q == scr_pkg::OP_LOAD) begin
      x_d[{dl_slot_q, 1'b0}] = rd_data[31:0];
      x_d[{dl_slot_q, 1'b1}] = rd_data[63:32];
    end else if (dl_op_q == scr_pkg::OP_LOADX) begin
      x_d[{dl_slot_q, 1'b0}] = x_q[{dl_slot_q, 1'b0}] ^ rd_data[31:0];
      x_d[{dl_slot_q, 1'b1}] = x_q[{dl_slot_q, 1'b1}] ^ rd_data[63:32];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      x_q[i] <= x_d[i];
    end
    // Chunk input kept for the feed-forward add.
    if (dl_op_q == scr_pkg::OP_LOAD || dl_op_q == scr_pkg::OP_LOADX) begin
      t_q[{dl_slot_q, 1'b0}] <= x_d[{dl_slot_q, 1'b0}];
      t_q[{dl_slot_q, 1'b1}] <= x_d[{dl_slot_q, 1'b1}];
    end
  end

  // Work/mix banks: input load goes to the current bank, Salsa output to the other.
  assign x_wdata = cmd_i.in_we ? in_word_i : xword;
  assign x_waddr = cmd_i.in_we ? cmd_i.xaddr[WW-1:0] : cmd_i.wxaddr[WW-1:0];
  assign x_we[0] = (cmd_i.in_we && !cmd_i.cur) ||
                   (cmd_i.wr_en && !cmd_i.wr_v && cmd_i.cur);
  assign x_we[1] = (cmd_i.in_we && cmd_i.cur) ||
                   (cmd_i.wr_en && !cmd_i.wr_v && !cmd_i.cur);

  assign v_we    = (dl_op_q == scr_pkg::OP_COPY) || (cmd_i.wr_en && cmd_i.wr_v);
  assign v_wdata = (dl_op_q == scr_pkg::OP_COPY) ? rd_data : xword;
  assign v_waddr = (dl_op_q == scr_pkg::OP_COPY) ? dl_waddr_q : cmd_i.waddr[VAW-1:0];

  scr_ram #(.WIDTH(64), .DEPTH(XDEPTH)) u_bank0 (
    .clk_i, .we_i(x_we[0]), .waddr_i(x_waddr), .wdata_i(x_wdata),
    .re_i(cmd_i.rd_en), .raddr_i(cmd_i.xaddr[WW-1:0]), .rdata_o(xr0)
  );

  scr_ram #(.WIDTH(64), .DEPTH(XDEPTH)) u_bank1 (
    .clk_i, .we_i(x_we[1]), .waddr_i(x_waddr), .wdata_i(x_wdata),
    .re_i(cmd_i.rd_en), .raddr_i(cmd_i.xaddr[WW-1:0]), .rdata_o(xr1)
  );

  scr_ram #(.WIDTH(64), .DEPTH(VDEPTH)) u_pad (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .re_i(cmd_i.rd_en), .raddr_i(cmd_i.vaddr[VAW-1:0]), .rdata_o(vr)
  );

  assign out_word_o   = xcur;
  assign sts_o.x0_low = x_q[0][scr_pkg::XLOW_W-1:0];
endmodule

[hw/rtl/scr_ctrl.sv]
// ROMix sequencer: config registers, load/fill/loop/output control.
module scr_ctrl #(
  parameter int unsigned MAX_R      = 4,
  parameter int unsigned MAX_LOG2_N = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [3:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             out_last_o,
  input  scr_pkg::dp_sts_t sts_i,
  output scr_pkg::dp_cmd_t cmd_o
);
  localparam int unsigned CW = $clog2(2 * MAX_R);
  localparam int unsigned WW = CW + 3;
  localparam int unsigned LW = MAX_LOG2_N;
  localparam int unsigned BW = MAX_LOG2_N + 1;

  typedef enum logic [3:0] {
    S_IN, S_COPY, S_COPY_WAIT, S_PRE, S_PRE_WAIT, S_LOAD, S_LOAD_WAIT,
    S_ROUND, S_FINAL, S_WRITE, S_OUT_RD, S_OUT_VALID
  } state_e;

  typedef enum logic {PH_FILL, PH_LOOP} phase_e;

  state_e         state_q;
  phase_e         phase_q;
  logic [2:0]     bf_q;
  logic [3:0]     lc_q;
  logic [6:0]     cnt_q;
  logic [CW-1:0]  r_q;
  logic [3:0]     lg_q;
  logic [WW-1:0]  k_q;
  logic [2:0]     w_q;
  logic [CW-1:0]  c_q;
  logic [BW-1:0]  i_q;
  logic [LW-1:0]  j_q;
  logic           cur_q;

  logic [2:0]    rr;
  logic [CW-1:0] r_eff;
  logic [3:0]    lg_eff;
  logic [WW:0]   words_in, words_q;
  logic [6:0]    cnt_n;
  logic          done_in;
  logic [WW-1:0] lastk;
  logic [CW-1:0] lastc, pos, half_c;
  logic [BW-1:0] n_q;
  logic [LW-1:0] nmask, src_blk;
  logic          dst_v;

  // Clamp the registers to the supported range.
  always_comb begin
    if (bf_q == 3'd0) begin
      rr = 3'd1;
    end else if (32'(bf_q) > MAX_R) begin
      rr = 3'(MAX_R);
    end else begin
      rr = bf_q;
    end
  end

  assign r_eff    = CW'(rr);
  assign lg_eff   = (32'(lc_q) > MAX_LOG2_N) ? 4'(MAX_LOG2_N) : lc_q;
  assign words_in = {r_eff, 4'b0};
  assign cnt_n    = cnt_q + 7'd1;
  assign done_in  = cnt_n >= 7'(words_in);
  assign words_q  = {r_q, 4'b0};
  assign lastk    = WW'(words_q - 1'b1);
  assign lastc    = CW'({r_q, 1'b0} - 1'b1);
  assign half_c   = c_q >> 1;
  assign pos      = c_q[0] ? CW'(r_q + half_c) : half_c;
  assign n_q      = BW'(1) << lg_q;
  assign nmask    = LW'(n_q - 1'b1);
  assign dst_v    = (phase_q == PH_FILL) && (i_q != n_q);
  assign src_blk  = (phase_q == PH_FILL) ? LW'(i_q - 1'b1) : j_q;

  always_comb begin
    cmd_o     = '0;
    cmd_o.cur = cur_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = (k_q == lastk);
    case (state_q)
      S_IN: begin
        in_ready_o   = 1'b1;
        cmd_o.in_we  = in_valid_i;
        cmd_o.xaddr  = scr_pkg::XADDR_W'(cnt_q[WW-1:0]);
      end
      S_COPY: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_x  = 1'b1;
        cmd_o.xaddr = scr_pkg::XADDR_W'(k_q);
        cmd_o.op    = scr_pkg::OP_COPY;
        cmd_o.waddr = scr_pkg::VADDR_W'({LW'(0), k_q});
      end
      S_PRE, S_LOAD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_x  = (phase_q == PH_LOOP);
        cmd_o.rd_v  = 1'b1;
        cmd_o.slot  = w_q;
        if (state_q == S_PRE) begin
          cmd_o.op    = scr_pkg::OP_LOAD;
          cmd_o.xaddr = scr_pkg::XADDR_W'({lastc, w_q});
          cmd_o.vaddr = scr_pkg::VADDR_W'({src_blk, lastc, w_q});
        end else begin
          cmd_o.op    = scr_pkg::OP_LOADX;
          cmd_o.xaddr = scr_pkg::XADDR_W'({c_q, w_q});
          cmd_o.vaddr = scr_pkg::VADDR_W'({src_blk, c_q, w_q});
        end
      end
      S_ROUND: begin
        cmd_o.round_en  = 1'b1;
        cmd_o.round_row = w_q[0];
      end
      S_FINAL: begin
        cmd_o.final_en = 1'b1;
      end
      S_WRITE: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_v   = dst_v;
        cmd_o.slot   = w_q;
        cmd_o.wxaddr = scr_pkg::XADDR_W'({pos, w_q});
        cmd_o.waddr  = scr_pkg::VADDR_W'({LW'(i_q), pos, w_q});
      end
      S_OUT_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_x  = 1'b1;
        cmd_o.xaddr = scr_pkg::XADDR_W'(k_q);
      end
      S_OUT_VALID: begin
        out_valid_o = 1'b1;
      end
      default: begin
        // wait states: read data still lands, bank select must hold
        cmd_o.op = scr_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IN;
      phase_q <= PH_FILL;
      bf_q    <= 3'd1;
      lc_q    <= 4'd10;
      cnt_q   <= '0;
      r_q     <= CW'(1);
      lg_q    <= '0;
      k_q     <= '0;
      w_q     <= '0;
      c_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      cur_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == scr_pkg::CFG_BLOCK_FACTOR) begin
          bf_q <= cfg_data_i[2:0];
        end else if (cfg_idx_i == scr_pkg::CFG_LOG2_COST) begin
          lc_q <= cfg_data_i;
        end
      end
      case (state_q)
        S_IN: begin
          if (in_valid_i) begin
            if (done_in) begin
              cnt_q   <= '0;
              r_q     <= r_eff;
              lg_q    <= lg_eff;
              k_q     <= '0;
              state_q <= S_COPY;
            end else begin
              cnt_q <= cnt_n;
            end
          end
        end
        S_COPY: begin
          k_q <= k_q + 1'b1;
          if (k_q == lastk) begin
            state_q <= S_COPY_WAIT;
          end
        end
        S_COPY_WAIT: begin
          phase_q <= PH_FILL;
          i_q     <= BW'(1);
          w_q     <= '0;
          state_q <= S_PRE;
        end
        S_PRE: begin
          w_q <= w_q + 1'b1;
          if (w_q == 3'd7) begin
            state_q <= S_PRE_WAIT;
          end
        end
        S_PRE_WAIT: begin
          c_q     <= '0;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          w_q <= w_q + 1'b1;
          if (w_q == 3'd7) begin
            state_q <= S_LOAD_WAIT;
          end
        end
        S_LOAD_WAIT: begin
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          w_q <= w_q + 1'b1;
          if (w_q == 3'd7) begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: begin
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          w_q <= w_q + 1'b1;
          // Integerify: first word of the last chunk of the new X
          if (w_q == 3'd0 && c_q == lastc) begin
            j_q <= sts_i.x0_low[LW-1:0] & nmask;
          end
          if (w_q == 3'd7) begin
            if (c_q != lastc) begin
              c_q     <= c_q + 1'b1;
              state_q <= S_LOAD;
            end else if (phase_q == PH_FILL) begin
              state_q <= S_PRE;
              if (i_q == n_q) begin
                cur_q   <= ~cur_q;
                phase_q <= PH_LOOP;
                i_q     <= '0;
              end else begin
                i_q <= i_q + 1'b1;
              end
            end else begin
              cur_q <= ~cur_q;
              if (i_q == BW'(n_q - 1'b1)) begin
                k_q     <= '0;
                state_q <= S_OUT_RD;
              end else begin
                i_q     <= i_q + 1'b1;
                state_q <= S_PRE;
              end
            end
          end
        end
        S_OUT_RD: begin
          state_q <= S_OUT_VALID;
        end
        S_OUT_VALID: begin
          if (out_ready_i) begin
            if (k_q == lastk) begin
              state_q <= S_IN;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_q <= S_IN;
        end
      endcase
    end
  end
endmodule

[hw/rtl/scrypt_romix_core.sv]
// Top level of the scrypt ROMix (Salsa20/8 BlockMix) core.
//
//  channel | dir | transfer when        | payload
//  --------+-----+----------------------+-------------------------------
//  in_i    | in  | valid & ready        | in_word[63:0]
//  out_o   | out | valid & ready        | out_word[63:0], last_out
//  cfg     | in  | cfg_we_i             | cfg_idx_i[1:0], cfg_data_i[3:0]
//
// Steps per block (W = 16*r words, N = 2^log2_cost):
//   W load transfers, then a copy of the W words into the scratchpad,
//   then 2*N BlockMix passes,
//   then W output words, each read from a bank and then offered to the sink.
// The single Salsa20/8 round unit (one half-round per cycle) and the one-word-per-
// cycle scratchpad port set the mixing time.
// Async active-low reset returns the sequencer to the input state; the memories
// are not cleared. One block at a time: input is not taken while a block mixes
// or its result is being transferred.
module scrypt_romix_core #(
  parameter int unsigned MAX_R      = 4,
  parameter int unsigned MAX_LOG2_N = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [3:0]      cfg_data_i,
  scr_in_if.sink          in_i,
  scr_out_if.source       out_o
);
  scr_pkg::dp_cmd_t cmd;
  scr_pkg::dp_sts_t sts;

  // sequencer: owns config, counters and the bank role bit
  scr_ctrl #(.MAX_R(MAX_R), .MAX_LOG2_N(MAX_LOG2_N)) u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_last_o  (out_o.last_out),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: banks, scratchpad, Salsa round unit
  scr_dp #(.MAX_R(MAX_R), .MAX_LOG2_N(MAX_LOG2_N)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .in_word_i  (in_i.in_word),
    .out_word_o (out_o.out_word),
    .sts_o      (sts)
  );
endmodule

[hw/rtl/scr_checker.sv]
// Port-level checks for the ROMix core, bound to the top level.
module scr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_word_i,
  input logic        out_last_i
);
  // No input taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && in_ready_i))
    else $error("input ready while output valid");

  // After the last word the block returns to input.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (!out_valid_i && in_ready_i))
    else $error("output continues after last word");

  // An input transfer never directly produces a result.
  a_in_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("output right after input transfer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_word_i) && $stable(out_last_i)))
    else $error("stalled output changed");
endmodule

bind scrypt_romix_core scr_checker u_scr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.out_word),
  .out_last_i  (out_o.last_out)
);

[test/scrypt_romix_core_test.sv]
// Self-checking testbench for the scrypt ROMix core: table-driven blocks, then random blocks.
`timescale 1ns / 1ps

module scrypt_romix_core_test;

  localparam int unsigned TOP_R      = 4;
  localparam int unsigned TOP_LOG2_N = 10;
  localparam int unsigned RAND_WORDS = 130;
  // Cycles left after the last output word before registers may change.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Watchdog limit for the whole run; leave a wide margin.
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  typedef bit [63:0] chunk_t [8];
  typedef bit [63:0] blk_t [64];

  typedef struct {
    bit [63:0] word;
    bit        last;
  } out_beat_t;

  // Directed stimulus row: either a register write or one input word.
  typedef struct {
    bit        is_cfg;
    bit [1:0]  idx;
    bit [3:0]  data;
    bit [63:0] word;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [3:0] cfg_data_i;

  scr_in_if  in_if ();
  scr_out_if out_if ();

  scrypt_romix_core #(
    .MAX_R      (TOP_R),
    .MAX_LOG2_N (TOP_LOG2_N)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // 20 ns clock.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow state of the core: scratchpad V, the block being collected / X,
  // collection count and the two registers.
  // ---------------------------------------------------------------------------
  bit [63:0]   vpad [65536];
  blk_t        xblk;
  int unsigned collected;
  bit [2:0]    r_reg;
  bit [3:0]    cost_reg;
  bit [31:0]   sw [16];

  out_beat_t   mixed_q [$];
  int unsigned errors;
  bit          quiet;   // no random gaps on either side while set

  function automatic bit [31:0] rotl32(bit [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void qround(int a, int b, int c, int d);
    sw[b] ^= rotl32(sw[a] + sw[d], 7);
    sw[c] ^= rotl32(sw[b] + sw[a], 9);
    sw[d] ^= rotl32(sw[c] + sw[b], 13);
    sw[a] ^= rotl32(sw[d] + sw[c], 18);
  endfunction

  // Salsa20/8 over one 64-byte chunk, feed-forward add included.
  function automatic chunk_t salsa8(chunk_t src);
    chunk_t dst;
    for (int i = 0; i < 8; i++) begin
      sw[2*i]   = src[i][31:0];
      sw[2*i+1] = src[i][63:32];
    end
    for (int i = 0; i < 4; i++) begin
      qround(0, 4, 8, 12);   qround(5, 9, 13, 1);
      qround(10, 14, 2, 6);  qround(15, 3, 7, 11);
      qround(0, 1, 2, 3);    qround(5, 6, 7, 4);
      qround(10, 11, 8, 9);  qround(15, 12, 13, 14);
    end
    for (int i = 0; i < 8; i++) begin
      dst[i] = {sw[2*i+1] + src[i][63:32], sw[2*i] + src[i][31:0]};
    end
    return dst;
  endfunction

  // BlockMix: chain through the 2r chunks, even outputs first, odd after.
  function automatic blk_t block_mix(blk_t src, int unsigned r);
    blk_t   dst;
    chunk_t t, p;
    for (int k = 0; k < 8; k++) p[k] = src[(2*r-1)*8 + k];
    for (int unsigned i = 0; i < r; i++) begin
      for (int k = 0; k < 8; k++) t[k] = p[k] ^ src[16*i + k];
      p = salsa8(t);
      for (int k = 0; k < 8; k++) dst[8*i + k] = p[k];
      for (int k = 0; k < 8; k++) t[k] = p[k] ^ src[16*i + 8 + k];
      p = salsa8(t);
      for (int k = 0; k < 8; k++) dst[8*(r+i) + k] = p[k];
    end
    return dst;
  endfunction

  function automatic int unsigned eff_r();
    if (r_reg == 0) return 1;
    return (r_reg > TOP_R) ? TOP_R : r_reg;
  endfunction

  function automatic int unsigned eff_lg();
    return (cost_reg > TOP_LOG2_N) ? TOP_LOG2_N : cost_reg;
  endfunction

  // Fill V, then the N data-dependent passes; X ends in xblk.
  function automatic void romix(int unsigned r, int unsigned lg);
    int unsigned words;
    int unsigned n;
    int unsigned j;
    blk_t        y;
    words = 16 * r;
    n     = 1 << lg;
    for (int unsigned k = 0; k < words; k++) vpad[k] = xblk[k];
    for (int unsigned i = 1; i < n; i++) begin
      xblk = block_mix(xblk, r);
      for (int unsigned k = 0; k < words; k++) vpad[i*words + k] = xblk[k];
    end
    xblk = block_mix(xblk, r);
    for (int unsigned i = 0; i < n; i++) begin
      j = xblk[(2*r-1)*8] & (n - 1);
      y = xblk;
      for (int unsigned k = 0; k < words; k++) y[k] = xblk[k] ^ vpad[j*words + k];
      xblk = block_mix(y, r);
    end
  endfunction

  // One accepted input word; queues the mixed block when it completes.
  function automatic void absorb_word(bit [63:0] w);
    int unsigned r;
    int unsigned words;
    out_beat_t   b;
    r     = eff_r();
    words = 16 * r;
    xblk[collected & 63] = w;
    collected = (collected + 1) & 127;
    if (collected >= words) begin
      collected = 0;
      romix(r, eff_lg());
      for (int unsigned k = 0; k < words; k++) begin
        b.word = xblk[k];
        b.last = (k + 1 == words);
        mixed_q.push_back(b);
      end
    end
  endfunction

  task automatic report_mismatch(string what, bit [63:0] got, bit [63:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the scoreboard.
  // ---------------------------------------------------------------------------
  int unsigned sink_hold;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_hold    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (mixed_q.size() == 0) begin
          report_mismatch("unexpected output word", out_if.out_word, '0);
        end else begin
          if (out_if.out_word !== mixed_q[0].word)
            report_mismatch("out_word", out_if.out_word, mixed_q[0].word);
          if (out_if.last_out !== mixed_q[0].last)
            report_mismatch("last_out", out_if.last_out, mixed_q[0].last);
          void'(mixed_q.pop_front());
        end
      end
      // Stall count is drawn per transfer; ready is assigned once per edge.
      if (sink_hold > 0) begin
        sink_hold    <= sink_hold - 1;
        out_if.ready <= 1'b0;
      end else if (out_if.valid && out_if.ready) begin
        sink_hold    <= draw_gap();
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  longint unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------
  int unsigned words_sent;

  // Send one word; valid is left high so back-to-back transfers need no toggle.
  task automatic send_word(bit [63:0] w);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_word <= w;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_word(w);
    words_sent++;
  endtask

  // Drop valid in the step of the last transfer, then wait for all results.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (mixed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [3:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == scr_pkg::CFG_BLOCK_FACTOR) r_reg = data[2:0];
    else if (idx == scr_pkg::CFG_LOG2_COST) cost_reg = data;
    @(posedge clk_i);
  endtask

  function automatic bit [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  stim_row_t table_rows [$];

  task automatic add_word(bit [63:0] w);
    stim_row_t s;
    s = '{is_cfg: 1'b0, idx: '0, data: '0, word: w};
    table_rows.push_back(s);
  endtask

  task automatic add_cfg(bit [1:0] idx, bit [3:0] data);
    stim_row_t s;
    s = '{is_cfg: 1'b1, idx: idx, data: data, word: '0};
    table_rows.push_back(s);
  endtask

  initial begin
    int unsigned phase;
    int unsigned split;
    bit          split_load;

    errors       = 0;
    words_sent   = 0;
    quiet        = 1'b0;
    collected    = 0;
    r_reg        = 1;
    cost_reg     = 10;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = scr_pkg::CFG_BLOCK_FACTOR;
    cfg_data_i   = '0;
    in_if.valid   = 1'b0;
    in_if.in_word = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Block right after reset (r=1, N=1024) with extreme words, then a
    // zero block factor, zero cost, ignored indexes and a half-loaded block
    // that the random part completes.
    add_word(64'h0);                  add_word(64'hFFFF_FFFF_FFFF_FFFF);
    add_word(64'h0000_0000_FFFF_FFFF); add_word(64'hFFFF_FFFF_0000_0000);
    add_word(64'h5555_5555_5555_5555); add_word(64'hAAAA_AAAA_AAAA_AAAA);
    add_word(64'h8000_0000_0000_0001); add_word(64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 7; i++) add_word(64'h1 << (i * 9));
    add_word(64'h7FFF_FFFF_7FFF_FFFF);
    add_cfg(scr_pkg::CFG_BLOCK_FACTOR, 4'd0);
    add_cfg(scr_pkg::CFG_LOG2_COST, 4'd0);
    add_cfg(2'd2, 4'hF);
    add_cfg(2'd3, 4'h5);
    for (int i = 0; i < 8; i++) add_word(64'hFEDC_BA98_7654_3210 ^ i);

    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        drain();
        write_reg(table_rows[i].idx, table_rows[i].data);
      end else begin
        send_word(table_rows[i].word);
      end
    end

    // Random blocks. The first few phases are pinned: saturated block factor,
    // saturated cost, and a block-factor shrink past the collected count.
    words_sent = 0;
    phase      = 0;
    while (words_sent < RAND_WORDS || collected != 0) begin
      quiet = ($urandom_range(0, 4) == 0);
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin
            write_reg(scr_pkg::CFG_BLOCK_FACTOR, 4'd15);
            write_reg(scr_pkg::CFG_LOG2_COST, 4'd2);
          end
          2: begin
            write_reg(scr_pkg::CFG_BLOCK_FACTOR, 4'd8);
            write_reg(scr_pkg::CFG_LOG2_COST, 4'd15);
          end
          3: begin
            write_reg(scr_pkg::CFG_BLOCK_FACTOR, 4'd2);
            write_reg(scr_pkg::CFG_LOG2_COST, 4'd1);
          end
          default: begin
            write_reg(scr_pkg::CFG_BLOCK_FACTOR, 4'($urandom_range(0, 15)));
            write_reg(scr_pkg::CFG_LOG2_COST, 4'($urandom_range(0, 4)));
            if ($urandom_range(0, 5) == 0) write_reg(2'($urandom_range(2, 3)), 4'($urandom));
          end
        endcase
      end
      split_load = (phase == 3) || ($urandom_range(0, 3) == 0);
      split      = (phase == 3) ? 20 : $urandom_range(1, 16 * eff_r() - 1);
      do begin
        send_word(rand_word());
        if (split_load && collected == split) begin
          // Registers change with a block part collected.
          split_load = 1'b0;
          drain();
          if (phase == 3) write_reg(scr_pkg::CFG_BLOCK_FACTOR, 4'd1);
          else write_reg(scr_pkg::CFG_BLOCK_FACTOR, 4'($urandom_range(0, 7)));
        end
      end while (collected != 0);
      phase++;
    end

    in_if.valid <= 1'b0;
    while (mixed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
